/* src/mexp_pkg.sv */
package mexp_pkg;

    // fixed width of every payload field
    localparam int FIELD_W = 64;

    // arithmetic width: only the low OPERAND_WIDTH bits of each field are used
    localparam int OPERAND_WIDTH = 64;

    // bit counter width of the multiplier
    localparam int CNT_W = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

    typedef logic [FIELD_W-1:0]       t_field;
    typedef logic [OPERAND_WIDTH-1:0] t_opnd;

    // status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

endpackage

/* src/mexp_if.sv */
// operand channel
interface mexp_in_if;
    import mexp_pkg::*;

    logic   valid;
    logic   ready;
    t_field base_value;
    t_field exponent;
    t_field modulus;

    modport source (output valid, output base_value, output exponent, output modulus,
                    input ready);
    modport sink   (input valid, input base_value, input exponent, input modulus,
                    output ready);
endinterface

// result channel
interface mexp_out_if;
    import mexp_pkg::*;

    logic   valid;
    logic   ready;
    t_field power_residue;
    logic   zero_modulus;

    modport source (output valid, output power_residue, output zero_modulus, input ready);
    modport sink   (input valid, input power_residue, input zero_modulus, output ready);
endinterface

/* src/modular_exponentiation_top.sv */
// channel | dir | handshake     | payload
// i_in    | in  | valid / ready | base_value, exponent, modulus (64 bits each)
// o_out   | out | valid / ready | power_residue (64 bits), zero_modulus (1 bit)
//
// one item at a time; i_in.ready is high only while the sequencer is idle
// each modular multiply runs in the shared shift-add unit
// an item runs k modular multiplies, k = base reduction plus n squares plus one multiply
// per set bit, n = significant exponent bits
// a zero or one modulus skips the multiplier; a stalled o_out holds the sequencer
// in its final state until the result register frees; synchronous active-low reset
module modular_exponentiation_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mexp_in_if.sink    i_in,
    mexp_out_if.source o_out
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL_R,
        ST_SQR,
        ST_FINISH
    } t_state;

    t_state   r_state;
    t_opnd    r_b;
    t_opnd    r_e;
    t_opnd    r_m;
    t_opnd    r_r;
    logic     r_err;
    logic     r_mm_start;
    t_opnd    r_mm_a;
    t_opnd    r_mm_b;
    logic     r_out_valid;
    t_opnd    r_out_residue;
    logic     r_out_zero;

    t_mm_stat w_mm_stat;
    t_opnd    w_mm_result;
    t_opnd    w_in_b;
    t_opnd    w_in_e;
    t_opnd    w_in_m;

    // only the low operand bits take part
    assign w_in_b = i_in.base_value[OPERAND_WIDTH-1:0];
    assign w_in_e = i_in.exponent[OPERAND_WIDTH-1:0];
    assign w_in_m = i_in.modulus[OPERAND_WIDTH-1:0];

    // shared modular multiplier
    mexp_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mm_start),
        .i_a      (r_mm_a),
        .i_b      (r_mm_b),
        .i_m      (r_m),
        .o_stat   (w_mm_stat),
        .o_result (w_mm_result)
    );

    // square and multiply sequencer, exponent lsb first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mm_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mm_start <= 1'b0;
            if (r_out_valid && o_out.ready && r_state != ST_FINISH) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_e   <= w_in_e;
                        r_m   <= w_in_m;
                        r_err <= (w_in_m == '0);
                        if (w_in_m == '0 || w_in_m == t_opnd'(1)) begin
                            r_r     <= '0;
                            r_state <= ST_FINISH;
                        end else begin
                            // base mod m as 1 * base mod m
                            r_r        <= t_opnd'(1);
                            r_mm_a     <= t_opnd'(1);
                            r_mm_b     <= w_in_b;
                            r_mm_start <= 1'b1;
                            r_state    <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE: begin
                    if (w_mm_stat.done) begin
                        r_b     <= w_mm_result;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (r_e == '0) begin
                        r_state <= ST_FINISH;
                    end else if (r_e[0]) begin
                        r_mm_a     <= r_r;
                        r_mm_b     <= r_b;
                        r_mm_start <= 1'b1;
                        r_state    <= ST_MUL_R;
                    end else begin
                        r_mm_a     <= r_b;
                        r_mm_b     <= r_b;
                        r_mm_start <= 1'b1;
                        r_e        <= r_e >> 1;
                        r_state    <= ST_SQR;
                    end
                end
                ST_MUL_R: begin
                    if (w_mm_stat.done) begin
                        r_r        <= w_mm_result;
                        r_mm_a     <= r_b;
                        r_mm_b     <= r_b;
                        r_mm_start <= 1'b1;
                        r_e        <= r_e >> 1;
                        r_state    <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    if (w_mm_stat.done) begin
                        r_b     <= w_mm_result;
                        r_state <= ST_CHECK;
                    end
                end
                ST_FINISH: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_residue <= r_r;
                        r_out_zero    <= r_err;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.power_residue = FIELD_W'(r_out_residue);
    assign o_out.zero_modulus  = r_out_zero;

`ifndef SYNTHESIS
    // the multiplier is never restarted while it is still working
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mm_start |-> !w_mm_stat.busy)
        else $error("multiplier started while busy");

    // no item is taken while the multiplier runs
    a_ready_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !w_mm_stat.busy && !r_mm_start)
        else $error("input ready while multiply in flight");

    // a multiply only finishes in a state that waits for it
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mm_stat.done |-> (r_state == ST_REDUCE || r_state == ST_MUL_R
                            || r_state == ST_SQR))
        else $error("multiply finished in unexpected state");

    // a zero modulus always reports a zero residue
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_zero |-> r_out_residue == '0)
        else $error("zero modulus with nonzero residue");
`endif

endmodule

/* src/mexp_mulmod.sv */
// (a * b) mod m, one multiplier bit per cycle, msb first; needs a < m, m > 1
module mexp_mulmod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  mexp_pkg::t_opnd    i_a,
    input  mexp_pkg::t_opnd    i_b,
    input  mexp_pkg::t_opnd    i_m,
    output mexp_pkg::t_mm_stat o_stat,
    output mexp_pkg::t_opnd    o_result
);
    import mexp_pkg::*;

    localparam int SUM_W = OPERAND_WIDTH + 2;

    t_opnd            r_acc;
    t_opnd            r_a;
    t_opnd            r_b;
    t_opnd            r_m;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [SUM_W-1:0] w_sum;
    logic [SUM_W:0]   w_sub1;
    logic [SUM_W:0]   w_sub2;
    t_opnd            n_acc;

    // 2*acc + bit*a stays below 3m, so at most two subtractions of m
    always_comb begin
        w_sum  = {1'b0, r_acc, 1'b0} + (r_b[OPERAND_WIDTH-1] ? SUM_W'(r_a) : '0);
        w_sub1 = {1'b0, w_sum} - (SUM_W + 1)'(r_m);
        w_sub2 = {1'b0, w_sum} - (SUM_W + 1)'({r_m, 1'b0});
        if (!w_sub2[SUM_W]) begin
            n_acc = w_sub2[OPERAND_WIDTH-1:0];
        end else if (!w_sub1[SUM_W]) begin
            n_acc = w_sub1[OPERAND_WIDTH-1:0];
        end else begin
            n_acc = w_sum[OPERAND_WIDTH-1:0];
        end
    end

    // operand capture and bit sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_m    <= i_m;
                r_cnt  <= CNT_W'(OPERAND_WIDTH - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_b   <= r_b << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_acc;

endmodule

/* verif/modular_exponentiation_top_tb.sv */
`timescale 1ns / 100ps

module modular_exponentiation_top_tb;
    import mexp_pkg::*;

    localparam int     RANDOM_ITEMS = 100;
    localparam int     LONG_HOLD    = 20000;
    localparam int     DRAIN_CYCLES = 200;
    localparam longint CYCLE_LIMIT  = 4_000_000;
    localparam t_field ALL_ONES     = '1;
    // largest prime below 2^64
    localparam t_field PRIME_64     = 64'hFFFF_FFFF_FFFF_FFC5;

    typedef struct {
        t_field      base_value;
        t_field      exponent;
        t_field      modulus;
        int unsigned gap;
        bit          drain_first;
    } t_operand_item;

    typedef struct packed {
        t_field power_residue;
        logic   zero_modulus;
    } t_power_result;

    typedef logic [2*OPERAND_WIDTH-1:0] t_wide;

    logic i_clk;
    logic i_rst_n;

    mexp_in_if  in_ch ();
    mexp_out_if out_ch ();

    modular_exponentiation_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_operand_item operand_q[$];
    t_power_result residue_expect_q[$];

    t_operand_item drv_item;
    bit            drv_have_item = 1'b0;
    int unsigned   drv_wait      = 0;
    int unsigned   sink_wait     = 0;
    int unsigned   hold_left     = 0;
    bit            hold_done     = 1'b0;
    int            long_hold_at  = -1;
    bit            in_accepted   = 1'b0;
    bit            out_accepted  = 1'b0;
    int            items_accepted   = 0;
    int            results_checked  = 0;
    int            zero_mod_results = 0;
    int            wide_exp_items   = 0;
    int            error_count      = 0;
    longint        cycle_count      = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // exact (a * b) mod m over the full double width
    function automatic t_opnd mul_reduce(t_opnd a, t_opnd b, t_opnd m);
        t_wide prod;
        prod = t_wide'(a) * t_wide'(b);
        return t_opnd'(prod % t_wide'(m));
    endfunction

    // expected result of one operand set, right-to-left square and multiply
    function automatic t_power_result power_residue_of(t_field base_in, t_field exp_in,
                                                       t_field mod_in);
        t_opnd         b;
        t_opnd         e;
        t_opnd         m;
        t_opnd         acc;
        t_power_result res;
        b   = base_in[OPERAND_WIDTH-1:0];
        e   = exp_in[OPERAND_WIDTH-1:0];
        m   = mod_in[OPERAND_WIDTH-1:0];
        res = '0;
        if (m == '0) begin
            res.zero_modulus = 1'b1;
        end else if (m != t_opnd'(1)) begin
            acc = t_opnd'(1);
            b   = b % m;
            while (e != '0) begin
                if (e[0]) begin
                    acc = mul_reduce(acc, b, m);
                end
                e = e >> 1;
                b = mul_reduce(b, b, m);
            end
            res.power_residue = t_field'(acc);
        end
        return res;
    endfunction

    function automatic t_field rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_operands(t_field b, t_field e, t_field m, bit drain, bit no_gap);
        t_operand_item it;
        it.base_value  = b;
        it.exponent    = e;
        it.modulus     = m;
        it.gap         = no_gap ? 0 : $urandom_range(0, 15);
        it.drain_first = drain;
        if (e[FIELD_W-1]) begin
            wide_exp_items++;
        end
        operand_q.push_back(it);
    endtask

    // stimulus and end of run
    initial begin
        t_field      b;
        t_field      e;
        t_field      m;
        int unsigned len;

        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.base_value     = '0;
        in_ch.exponent       = '0;
        in_ch.modulus        = '0;
        out_ch.ready         = 1'b0;

        // directed corners
        queue_operands(64'd5, 64'd3, 64'd13, 1'b0, 1'b0);
        queue_operands(rand_word(), rand_word(), '0, 1'b0, 1'b0);
        queue_operands(ALL_ONES, ALL_ONES, '0, 1'b0, 1'b0);
        queue_operands(ALL_ONES, ALL_ONES, 64'd1, 1'b0, 1'b0);
        queue_operands(rand_word(), '0, 64'd7, 1'b0, 1'b0);
        queue_operands('0, '0, ALL_ONES, 1'b0, 1'b0);
        queue_operands('0, 64'd5, 64'd17, 1'b0, 1'b0);
        queue_operands(ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, 1'b0);
        queue_operands(ALL_ONES - 1, 64'd2, ALL_ONES, 1'b0, 1'b0);
        queue_operands(64'd2, 64'd64, ALL_ONES, 1'b0, 1'b0);
        queue_operands(64'd3, rand_word(), 64'h8000_0000_0000_0000, 1'b0, 1'b0);
        queue_operands(rand_word(), {48'd0, 16'($urandom_range(0, 65535))},
                       64'h1_0000_0001, 1'b0, 1'b0);
        queue_operands(ALL_ONES, 64'd1, 64'd1000003, 1'b0, 1'b0);
        queue_operands(rand_word(), rand_word(), 64'd2, 1'b0, 1'b0);
        queue_operands(PRIME_64 - 1, ALL_ONES, PRIME_64, 1'b0, 1'b0);
        queue_operands(rand_word(), PRIME_64 - 1, PRIME_64, 1'b0, 1'b0);
        queue_operands('0, 64'd1, 64'd2, 1'b0, 1'b0);
        queue_operands(ALL_ONES, 64'd1, 64'h8000_0000_0000_0000, 1'b0, 1'b0);

        // hold the result side shortly after the random part begins
        long_hold_at = operand_q.size() + 3;

        // random operand sets, mostly short exponents
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(0, 19))
                0:       m = '0;
                1:       m = 64'd1;
                2, 3:    m = t_field'($urandom_range(2, 255));
                4, 5:    m = {31'd0, 1'b1, $urandom()};
                6:       m = ALL_ONES - t_field'($urandom_range(0, 255));
                default: m = rand_word();
            endcase
            case ($urandom_range(0, 9))
                0: begin
                    e = rand_word();
                end
                1: begin
                    e = t_field'($urandom_range(0, 1));
                end
                default: begin
                    len = $urandom_range(1, 16);
                    e   = (rand_word() & ((t_field'(1) << len) - 1)) | (t_field'(1) << (len - 1));
                end
            endcase
            case ($urandom_range(0, 5))
                0:       b = '0;
                1:       b = m - 1;
                2:       b = t_field'($urandom_range(0, 255));
                default: b = rand_word();
            endcase
            queue_operands(b, e, m, n == 0 || n == 50, n >= 40 && n < 60);
        end

        // reset
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every operand set to go in and every result to come back
        while (operand_q.size() != 0 || drv_have_item || in_ch.valid ||
               residue_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d operand sets: %0d zero-modulus results, %0d with exponent msb set",
                 results_checked, zero_mod_results, wide_exp_items);
        $display("included a %0d-cycle result stall with input backpressure and a drain pause",
                 LONG_HOLD);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // operand driver, fed from operand_q
    always @(negedge i_clk) begin : drive_operands
        bit offer;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            offer = in_ch.valid && !in_accepted;
            if (!offer) begin
                if (!drv_have_item && operand_q.size() != 0) begin
                    drv_item      = operand_q.pop_front();
                    drv_have_item = 1'b1;
                    drv_wait      = drv_item.gap;
                end
                if (drv_have_item) begin
                    // drain pause: no new item until every result is back
                    if (drv_item.drain_first && residue_expect_q.size() != 0) begin
                        offer = 1'b0;
                    end else if (drv_wait != 0) begin
                        drv_wait--;
                    end else begin
                        in_ch.base_value <= drv_item.base_value;
                        in_ch.exponent   <= drv_item.exponent;
                        in_ch.modulus    <= drv_item.modulus;
                        offer            = 1'b1;
                        drv_have_item    = 1'b0;
                    end
                end
            end
            in_ch.valid <= offer;
        end
    end

    // one long result-side hold, counted here
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && items_accepted == long_hold_at) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result ready with random stalls, none during the burst window
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (out_accepted) begin
                sink_wait = (results_checked >= 60 && results_checked < 80) ?
                            0 : $urandom_range(0, 15);
            end else if (sink_wait != 0) begin
                sink_wait--;
            end
            out_ch.ready <= (sink_wait == 0) && (hold_left == 0);
        end
    end

    // record accepted operands and check accepted results
    always @(posedge i_clk) begin : sample_channels
        t_power_result want;
        in_accepted  <= i_rst_n && in_ch.valid && in_ch.ready;
        out_accepted <= i_rst_n && out_ch.valid && out_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            residue_expect_q.push_back(power_residue_of(in_ch.base_value, in_ch.exponent,
                                                        in_ch.modulus));
            items_accepted++;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_checked++;
            if (residue_expect_q.size() == 0) begin
                error_count++;
                $display("%0t: result with none expected: residue %h, zero_modulus %b",
                         $time, out_ch.power_residue, out_ch.zero_modulus);
            end else begin
                want = residue_expect_q.pop_front();
                if (want.power_residue !== out_ch.power_residue) begin
                    error_count++;
                    $display("%0t: power_residue mismatch: expected %h, actual %h",
                             $time, want.power_residue, out_ch.power_residue);
                end
                if (want.zero_modulus !== out_ch.zero_modulus) begin
                    error_count++;
                    $display("%0t: zero_modulus mismatch: expected %b, actual %b",
                             $time, want.zero_modulus, out_ch.zero_modulus);
                end
                if (want.zero_modulus) begin
                    zero_mod_results++;
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, residue_expect_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
